### rtl/bee_pkg.sv
// Shared types and constants for the boolean expression evaluator.
`timescale 1ns / 1ps
`default_nettype none

package bee_pkg;

   localparam int MAX_NEST    = 16;
   localparam int LEVEL_W     = $clog2(MAX_NEST + 1);
   localparam int ADDR_W      = $clog2(MAX_NEST);
   localparam int SYM_W       = 8;
   localparam int VAR_W       = 26;
   localparam int VAR_IDX_W   = $clog2(VAR_W);

   localparam logic [SYM_W-1:0] SYM_NOT   = 8'h2D;  // '-'
   localparam logic [SYM_W-1:0] SYM_AND   = 8'h2A;  // '*'
   localparam logic [SYM_W-1:0] SYM_OR    = 8'h2B;  // '+'
   localparam logic [SYM_W-1:0] SYM_OPEN  = 8'h28;  // '('
   localparam logic [SYM_W-1:0] SYM_CLOSE = 8'h29;  // ')'
   localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;  // '0'
   localparam logic [SYM_W-1:0] SYM_ONE   = 8'h31;  // '1'
   localparam logic [SYM_W-1:0] SYM_A     = 8'h41;  // 'A'
   localparam logic [SYM_W-1:0] SYM_Z     = 8'h5A;  // 'Z'

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(MAX_NEST);

   typedef struct packed {
      logic or_bit;
      logic and_bit;
      logic not_bit;
   } frame_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      frame_type         wr_frame;
      logic [ADDR_W-1:0] rd_addr;
   } stack_req_type;

endpackage

`default_nettype wire

### rtl/boolean_expression_evaluator.sv
// Top level: streaming boolean expression evaluator.
//
//  channel  | direction | tdata / data            | tuser  | tlast
//  req_     | in        | [7:0] symbol            | -      | last
//  rsp_     | out       | [0] value, [7:1] zero   | error  | -
//  csr_     | in        | [25:0] variable_values  | -      | -
//
// A symbol is taken every cycle while req_tready is high; each result is registered.
// The frame stack is a 16-entry memory read every cycle at the next top of stack;
// a push to that same entry is forwarded, so push and pop may follow back to back.
// Reset clears variables, accumulators, level and output valid bits, not stack entries.
// Two result registers (output plus skid) let symbols flow while rsp_tready is low;
// req_tready drops only when both hold a result.
`timescale 1ns / 1ps
`default_nettype none

module boolean_expression_evaluator
   import bee_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [7:0]       req_tdata,   // [7:0] symbol
   input  wire logic             req_tlast,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [7:0]            rsp_tdata,   // [0] value, [7:1] zero
   output logic                  rsp_tuser,   // [0] error
   input  wire logic             csr_wr_en,
   input  wire logic [VAR_W-1:0] csr_wr_data
);

   logic [VAR_W-1:0]   vars_ff;
   logic               or_ff, or_in;
   logic               and_ff, and_in;
   logic               not_ff, not_in;
   logic               err_ff, err_in;
   logic [LEVEL_W-1:0] level_ff, level_in;

   logic               accept;
   logic               push_res;
   logic               res_value, res_error;
   frame_type          top_frame;
   stack_req_type      stack_req;
   logic [SYM_W-1:0]   var_off;
   logic               var_bit;
   logic               inner;
   logic               pop_level_ok;
   logic [LEVEL_W-1:0] level_dec;

   logic               out_valid_ff, skid_valid_ff;
   logic               out_value_ff, out_error_ff;
   logic               skid_value_ff, skid_error_ff;
   logic               pop_res;

   assign accept  = req_tvalid && req_tready;
   assign var_off = req_tdata - SYM_A;
   assign var_bit = vars_ff[var_off[VAR_IDX_W-1:0]];
   assign inner   = or_ff | and_ff;
   assign pop_level_ok = (level_ff != '0) && (level_ff <= LEVEL_MAX);
   assign level_dec = level_ff - LEVEL_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         vars_ff <= '0;
      end else if (csr_wr_en) begin
         vars_ff <= csr_wr_data;
      end
   end

   // symbol decode: next frame, level and stack access
   always_comb begin
      or_in  = or_ff;
      and_in = and_ff;
      not_in = not_ff;
      err_in = err_ff;
      level_in = level_ff;
      stack_req.wr_en    = 1'b0;
      stack_req.wr_addr  = level_ff[ADDR_W-1:0];
      stack_req.wr_frame = '{or_bit: or_ff, and_bit: and_ff, not_bit: not_ff};
      if (accept) begin
         priority if (req_tdata == SYM_NOT) begin
            not_in = ~not_ff;
         end else if (req_tdata == SYM_ZERO || req_tdata == SYM_ONE) begin
            and_in = and_ff & (req_tdata[0] ^ not_ff);
            not_in = 1'b0;
         end else if (req_tdata >= SYM_A && req_tdata <= SYM_Z) begin
            and_in = and_ff & (var_bit ^ not_ff);
            not_in = 1'b0;
         end else if (req_tdata == SYM_OR) begin
            or_in  = or_ff | and_ff;
            and_in = 1'b1;
            not_in = 1'b0;
         end else if (req_tdata == SYM_OPEN) begin
            if (level_ff < LEVEL_MAX) begin
               stack_req.wr_en = 1'b1;
               level_in = level_ff + LEVEL_W'(1);
               or_in  = 1'b0;
               and_in = 1'b1;
               not_in = 1'b0;
            end else begin
               err_in = 1'b1;
            end
         end else if (req_tdata == SYM_CLOSE) begin
            if (pop_level_ok) begin
               level_in = level_dec;
               or_in  = top_frame.or_bit;
               and_in = top_frame.and_bit & (inner ^ top_frame.not_bit);
               not_in = 1'b0;
            end else begin
               err_in = 1'b1;
            end
         end else begin
            // '*' and unknown symbols: hold
            err_in = err_ff;
         end
      end
      res_value = or_in | and_in;
      res_error = err_in | (level_in != '0);
      push_res  = accept && req_tlast;
      if (push_res) begin
         or_in  = 1'b0;
         and_in = 1'b1;
         not_in = 1'b0;
         err_in = 1'b0;
         level_in = '0;
      end
      // read the entry that will be top of stack next cycle
      stack_req.rd_addr = ADDR_W'(level_in - LEVEL_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         or_ff    <= 1'b0;
         and_ff   <= 1'b1;
         not_ff   <= 1'b0;
         err_ff   <= 1'b0;
         level_ff <= '0;
      end else begin
         or_ff    <= or_in;
         and_ff   <= and_in;
         not_ff   <= not_in;
         err_ff   <= err_in;
         level_ff <= level_in;
      end
   end

   bee_frame_stack u_stack (
      .clock     (clock),
      .reset     (reset),
      .stack_req (stack_req),
      .top_frame (top_frame)
   );

   // output register plus skid stage
   assign pop_res    = out_valid_ff && rsp_tready;
   assign req_tready = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || pop_res) begin
            out_valid_ff  <= skid_valid_ff || push_res;
            skid_valid_ff <= skid_valid_ff && push_res;
         end else if (push_res) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop_res) begin
         if (skid_valid_ff) begin
            out_value_ff  <= skid_value_ff;
            out_error_ff  <= skid_error_ff;
            skid_value_ff <= res_value;
            skid_error_ff <= res_error;
         end else begin
            out_value_ff  <= res_value;
            out_error_ff  <= res_error;
         end
      end else if (push_res) begin
         skid_value_ff <= res_value;
         skid_error_ff <= res_error;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_value_ff};
   assign rsp_tuser  = out_error_ff;

endmodule

`default_nettype wire

### rtl/bee_frame_stack.sv
// Frame stack memory with registered read and write forwarding.
`timescale 1ns / 1ps
`default_nettype none

module bee_frame_stack
   import bee_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire stack_req_type stack_req,
   output frame_type          top_frame
);

   frame_type mem [MAX_NEST];

   frame_type rd_data_ff;
   frame_type fwd_data_ff;
   logic      fwd_ff;
   logic      fwd_in;

   assign fwd_in = stack_req.wr_en && (stack_req.wr_addr == stack_req.rd_addr);

   always_ff @(posedge clock) begin
      if (stack_req.wr_en) begin
         mem[stack_req.wr_addr] <= stack_req.wr_frame;
      end
      rd_data_ff  <= mem[stack_req.rd_addr];
      fwd_data_ff <= stack_req.wr_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
   end

   // memory returns old data on a same-cycle write, so take the written frame
   assign top_frame = fwd_ff ? fwd_data_ff : rd_data_ff;

endmodule

`default_nettype wire

### rtl/bee_checker.sv
// Port-level checks for the boolean expression evaluator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bee_checker
   import bee_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic [7:0]       req_tdata,
   input wire logic             req_tlast,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [7:0]       rsp_tdata,
   input wire logic             rsp_tuser
);

   // no result survives reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // a final symbol reaches an empty output on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast && !rsp_tvalid |=> rsp_tvalid)
      else $error("result missing after last symbol");

   // an expression ending on an open group always flags an error
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast && (req_tdata == SYM_OPEN) && !rsp_tvalid
      |=> rsp_tvalid && rsp_tuser)
      else $error("open group at end not flagged");

endmodule

bind boolean_expression_evaluator bee_checker u_bee_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

### bench/tb_top.sv
// Self-checking testbench for the streaming boolean expression evaluator.
`timescale 1ns / 1ps

module tb_top;
   import bee_pkg::*;

   typedef struct packed {
      logic value;
      logic error;
   } verdict_t;

   typedef struct packed {
      logic [7:0] sym;
      logic       last;
      logic       fixed;   // 1: expected verdict typed in this row
      logic       value;
      logic       error;
   } stim_row_t;

   localparam int N_DIRECTED = 23;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata   = 8'h00;  // [7:0] symbol
   logic             req_tlast   = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic [7:0]       rsp_tdata;            // [0] value, [7:1] zero
   logic             rsp_tuser;            // [0] error
   logic             csr_wr_en   = 1'b0;
   logic [VAR_W-1:0] csr_wr_data = '0;

   // evaluator shadow state
   logic [VAR_W-1:0] var_bits = '0;
   logic             or_acc   = 1'b0;
   logic             and_acc  = 1'b1;
   logic             not_pend = 1'b0;
   logic             err_seen = 1'b0;
   int unsigned      depth    = 0;
   frame_type        frames [MAX_NEST];

   verdict_t   expected_verdicts [$];
   logic [7:0] pending_syms [$];

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_left     = 0;
   int unsigned fail_count    = 0;
   int unsigned symbols_sent  = 0;
   int unsigned exprs_sent    = 0;
   int unsigned verdicts_seen = 0;
   int unsigned input_stalls  = 0;
   int unsigned deepest       = 0;
   int unsigned nest_faults   = 0;

   stim_row_t directed_rows [N_DIRECTED] = '{
      '{SYM_A,     1'b1, 1'b1, 1'b0, 1'b0},
      '{SYM_NOT,   1'b0, 1'b0, 1'b0, 1'b0},
      '{SYM_Z,     1'b1, 1'b1, 1'b1, 1'b0},
      '{SYM_NOT,   1'b0, 1'b0, 1'b0, 1'b0},
      '{SYM_NOT,   1'b0, 1'b0, 1'b0, 1'b0},
      '{SYM_ONE,   1'b1, 1'b1, 1'b1, 1'b0},
      '{SYM_ONE,   1'b0, 1'b0, 1'b0, 1'b0},
      '{SYM_AND,   1'b0, 1'b0, 1'b0, 1'b0},
      '{SYM_ZERO,  1'b1, 1'b1, 1'b0, 1'b0},
      '{SYM_ZERO,  1'b0, 1'b0, 1'b0, 1'b0},
      '{SYM_OR,    1'b1, 1'b1, 1'b1, 1'b0},
      '{SYM_OPEN,  1'b0, 1'b0, 1'b0, 1'b0},
      '{SYM_CLOSE, 1'b1, 1'b1, 1'b1, 1'b0},
      '{SYM_CLOSE, 1'b1, 1'b1, 1'b1, 1'b1},
      '{SYM_OPEN,  1'b1, 1'b1, 1'b1, 1'b1},
      '{8'h00,     1'b1, 1'b1, 1'b1, 1'b0},
      '{8'hFF,     1'b1, 1'b1, 1'b1, 1'b0},
      '{SYM_NOT,   1'b0, 1'b0, 1'b0, 1'b0},
      '{SYM_OPEN,  1'b0, 1'b0, 1'b0, 1'b0},
      '{SYM_ZERO,  1'b0, 1'b0, 1'b0, 1'b0},
      '{SYM_OR,    1'b0, 1'b0, 1'b0, 1'b0},
      '{SYM_ZERO,  1'b0, 1'b0, 1'b0, 1'b0},
      '{SYM_CLOSE, 1'b1, 1'b0, 1'b0, 1'b0}
   };

   boolean_expression_evaluator uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic void fold_atom(input logic atom);
      and_acc  = and_acc & (atom ^ not_pend);
      not_pend = 1'b0;
   endfunction

   // Advance the shadow evaluator by one symbol; returns 1 when a verdict is due.
   function automatic bit eval_symbol(input logic [7:0] sym, input logic last,
                                      output verdict_t verdict);
      logic inner;
      verdict = '0;
      if (sym == SYM_NOT) begin
         not_pend = ~not_pend;
      end else if (sym == SYM_ZERO || sym == SYM_ONE) begin
         fold_atom(sym == SYM_ONE);
      end else if (sym >= SYM_A && sym <= SYM_Z) begin
         fold_atom(var_bits[sym - SYM_A]);
      end else if (sym == SYM_OR) begin
         or_acc   = or_acc | and_acc;
         and_acc  = 1'b1;
         not_pend = 1'b0;
      end else if (sym == SYM_OPEN) begin
         if (depth < MAX_NEST) begin
            frames[depth] = '{or_bit: or_acc, and_bit: and_acc, not_bit: not_pend};
            depth++;
            if (depth > deepest) deepest = depth;
            or_acc   = 1'b0;
            and_acc  = 1'b1;
            not_pend = 1'b0;
         end else begin
            err_seen = 1'b1;
            nest_faults++;
         end
      end else if (sym == SYM_CLOSE) begin
         if (depth > 0) begin
            inner = or_acc | and_acc;
            depth--;
            or_acc   = frames[depth].or_bit;
            and_acc  = frames[depth].and_bit;
            not_pend = frames[depth].not_bit;
            fold_atom(inner);
         end else begin
            err_seen = 1'b1;
            nest_faults++;
         end
      end
      if (!last) return 1'b0;
      verdict.value = or_acc | and_acc;
      verdict.error = err_seen | (depth != 0);
      or_acc   = 1'b0;
      and_acc  = 1'b1;
      not_pend = 1'b0;
      err_seen = 1'b0;
      depth    = 0;
      return 1'b1;
   endfunction

   function automatic logic [7:0] pick_atom();
      case ($urandom_range(3))
         0:       return SYM_ZERO;
         1:       return SYM_ONE;
         default: return SYM_A + 8'($urandom_range(VAR_W - 1));
      endcase
   endfunction

   // Append a well-formed expression: OR of terms, each an AND of factors.
   function automatic void build_expr(input int lvl);
      int terms;
      int factors;
      terms = $urandom_range(3, 1);
      for (int t = 0; t < terms; t++) begin
         if (t != 0) pending_syms.push_back(SYM_OR);
         factors = ($urandom_range(7) == 0) ? 0 : $urandom_range(3, 1);
         for (int f = 0; f < factors; f++) begin
            if (f != 0 && $urandom_range(1) == 1) pending_syms.push_back(SYM_AND);
            if ($urandom_range(2) == 0)
               repeat ($urandom_range(3, 1)) pending_syms.push_back(SYM_NOT);
            if (lvl < 4 && $urandom_range(4) == 0) begin
               pending_syms.push_back(SYM_OPEN);
               build_expr(lvl + 1);
               pending_syms.push_back(SYM_CLOSE);
            end else begin
               pending_syms.push_back(pick_atom());
            end
         end
      end
   endfunction

   // Mostly well-formed, some deep nests around the stack limit, some broken or noise.
   function automatic void build_random_expr();
      int kind;
      int n;
      pending_syms.delete();
      kind = $urandom_range(99);
      if (kind < 75) begin
         build_expr(0);
         // an expression needs at least one symbol to carry the last flag
         if (pending_syms.size() == 0) pending_syms.push_back(pick_atom());
      end else if (kind < 82) begin
         n = $urandom_range(MAX_NEST + 2, MAX_NEST - 3);
         repeat (n) pending_syms.push_back(SYM_OPEN);
         if ($urandom_range(1) == 1) pending_syms.push_back(SYM_NOT);
         pending_syms.push_back(pick_atom());
         repeat (n) pending_syms.push_back(SYM_CLOSE);
      end else if (kind < 93) begin
         build_expr(0);
         if (pending_syms.size() == 0) pending_syms.push_back(pick_atom());
         case ($urandom_range(3))
            0: pending_syms.insert($urandom_range(pending_syms.size()), 8'($urandom()));
            1: pending_syms.delete($urandom_range(pending_syms.size() - 1));
            2: pending_syms.insert($urandom_range(pending_syms.size()), SYM_CLOSE);
            default: pending_syms.insert($urandom_range(pending_syms.size()), SYM_OPEN);
         endcase
         if (pending_syms.size() == 0) pending_syms.push_back(8'($urandom()));
      end else begin
         repeat ($urandom_range(3, 1)) pending_syms.push_back(8'($urandom()));
      end
   endfunction

   // Offer one item, idling at random first; returns at the accepting edge.
   task automatic send_item(input logic [7:0] sym, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sym;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      symbols_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_vars(input logic [VAR_W-1:0] bits);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= bits;
      @(posedge clock);
      var_bits  = bits;
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input logic [VAR_W-1:0] bits, input int unsigned idle_pct,
                            input int unsigned stall_pct, input int unsigned budget,
                            input int unsigned hold_cycles);
      int unsigned count;
      verdict_t    verdict;
      count = 0;
      write_vars(bits);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      if (hold_cycles != 0) hold_left <= hold_cycles;
      while (count < budget) begin
         build_random_expr();
         foreach (pending_syms[i]) begin
            send_item(pending_syms[i], i == pending_syms.size() - 1);
            if (eval_symbol(pending_syms[i], i == pending_syms.size() - 1, verdict))
               expected_verdicts.push_back(verdict);
         end
         count += pending_syms.size();
         exprs_sent++;
      end
      drain();
   endtask

   // Long receiver hold-off, counted down here.
   always @(posedge clock) begin
      if (hold_left != 0) hold_left <= hold_left - 1;
   end

   always @(posedge clock) begin
      verdict_t want;
      if (!reset) begin
         if (req_tvalid && !req_tready) input_stalls++;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               $error("result with none expected: value %0b error %0b",
                      rsp_tdata[0], rsp_tuser);
               fail_count++;
            end else begin
               want = expected_verdicts.pop_front();
               verdicts_seen++;
               if (rsp_tdata[0] !== want.value) begin
                  $error("value: expected %0b, actual %0b", want.value, rsp_tdata[0]);
                  fail_count++;
               end
               if (rsp_tuser !== want.error) begin
                  $error("error: expected %0b, actual %0b", want.error, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[7:1] !== 7'd0) begin
                  $error("pad: expected %0h, actual %0h", 7'd0, rsp_tdata[7:1]);
                  fail_count++;
               end
            end
         end
      end
      if (hold_left != 0) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      verdict_t verdict;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed walk with the register still at its reset value
      foreach (directed_rows[r]) begin
         send_item(directed_rows[r].sym, directed_rows[r].last);
         if (eval_symbol(directed_rows[r].sym, directed_rows[r].last, verdict)) begin
            if (directed_rows[r].fixed) begin
               verdict.value = directed_rows[r].value;
               verdict.error = directed_rows[r].error;
            end
            expected_verdicts.push_back(verdict);
            exprs_sent++;
         end
      end
      drain();

      run_phase({VAR_W{1'b1}}, 0, 0, 300, 0);
      run_phase(VAR_W'($urandom()), 49, 0, 300, 0);
      run_phase('0, 0, 49, 300, 0);
      run_phase(VAR_W'($urandom()), 17, 17, 300, 0);
      // receiver holds off while items keep coming, so the block backs up
      run_phase(26'h1555555, 0, 0, 220, 400);

      repeat (8) @(posedge clock);
      if (expected_verdicts.size() != 0) begin
         $error("%0d expected results never arrived", expected_verdicts.size());
         fail_count++;
      end
      $display("Run covered %0d symbols in %0d expressions under six variable settings,",
               symbols_sent, exprs_sent);
      $display("%0d results checked, nesting to %0d, %0d nesting faults, %0d input stalls.",
               verdicts_seen, deepest, nest_faults, input_stalls);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
